// ----- rtl/tftpd_pkg.sv -----
package tftpd_pkg;

    // Packet kind held between beats: opcode value, or none / unknown.
    typedef enum logic [3:0] {
        KIND_NONE    = 4'd0,
        KIND_RRQ     = 4'd1,
        KIND_WRQ     = 4'd2,
        KIND_DATA    = 4'd3,
        KIND_ACK     = 4'd4,
        KIND_ERROR   = 4'd5,
        KIND_DIRQ    = 4'd6,
        KIND_LOGRQ   = 4'd7,
        KIND_DELRQ   = 4'd8,
        KIND_BCAST   = 4'd9,
        KIND_DISC    = 4'd10,
        KIND_UNKNOWN = 4'd15
    } t_kind;

    localparam logic       CMD_BEGIN       = 1'b0;
    localparam logic       CMD_BODY        = 1'b1;
    localparam logic [3:0] TYPE_UNKNOWN    = 4'd10;
    localparam logic [15:0] CODE_UNKNOWN   = 16'd4;
    localparam logic [15:0] OPCODE_MAX     = 16'd10;
    localparam logic [2:0] DATA_HDR_BYTES  = 3'd4;
    localparam logic [2:0] DATA_LEN_BYTES  = 3'd2;
    localparam logic [2:0] ERR_HDR_BYTES   = 3'd2;

    typedef struct packed {
        logic [3:0]  packet_type;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        done_res;
        logic [15:0] block_number;
        logic [15:0] data_size;
        logic [15:0] error_code;
        logic [7:0]  broadcast_flag;
    } t_result;

endpackage

// ----- rtl/tftp_style_packet_deframer_core.sv -----
// Channel | Direction | Handshake          | Payload
// input   | in        | i_valid / o_stall  | i_command, i_opcode_value, i_byte_value
// output  | out       | o_valid / i_stall  | o_packet_type ... o_broadcast_flag
//
// One beat per cycle while o_stall is low; the result of an accepted beat is
// formed combinationally from the header state and the beat and registered in
// the output register, or in the skid register while the output is stalled.
// Synchronous active-low reset clears the packet kind, header counters and
// stored header fields, and empties the output and skid registers.
// A stalled output parks one more result in a skid register; o_stall rises
// only while that skid register is full.
module tftp_style_packet_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [15:0] i_opcode_value,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_packet_type,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic        o_done_res,
    output logic [15:0] o_block_number,
    output logic [15:0] o_data_size,
    output logic [15:0] o_error_code,
    output logic [7:0]  o_broadcast_flag
);

    tftpd_pkg::t_kind   r_kind, n_kind;
    logic [2:0]         r_hdr_cnt, n_hdr_cnt;
    logic [15:0]        r_length, n_length;
    logic [15:0]        r_block, n_block;
    logic [15:0]        r_pay_cnt, n_pay_cnt;
    logic [15:0]        r_error, n_error;
    logic [7:0]         r_bcast, n_bcast;

    tftpd_pkg::t_result r_out, r_skid, res;
    logic               r_out_valid, r_skid_valid;
    logic               res_valid;
    logic               acc;
    logic               take;

    logic [15:0]        len_shift, blk_shift, err_shift;
    logic [15:0]        pay_inc;
    logic [2:0]         hdr_inc;
    logic [3:0]         kind_type;

    assign acc  = i_valid && !r_skid_valid;
    assign take = r_out_valid && !i_stall;

    assign len_shift = {r_length[7:0], i_byte_value};
    assign blk_shift = {r_block[7:0], i_byte_value};
    assign err_shift = {r_error[7:0], i_byte_value};
    assign pay_inc   = r_pay_cnt + 16'd1;
    assign hdr_inc   = r_hdr_cnt + 3'd1;
    assign kind_type = r_kind - 4'd1;

    always_comb begin
        n_kind    = r_kind;
        n_hdr_cnt = r_hdr_cnt;
        n_length  = r_length;
        n_block   = r_block;
        n_pay_cnt = r_pay_cnt;
        n_error   = r_error;
        n_bcast   = r_bcast;
        res       = '0;
        res.packet_type = kind_type;
        res_valid = 1'b0;

        if (i_command == tftpd_pkg::CMD_BEGIN) begin
            if (i_opcode_value == 16'd0) begin
                n_kind = tftpd_pkg::KIND_NONE;
            end else if (i_opcode_value <= tftpd_pkg::OPCODE_MAX) begin
                n_kind = tftpd_pkg::t_kind'(i_opcode_value[3:0]);
            end else begin
                n_kind = tftpd_pkg::KIND_UNKNOWN;
            end
            n_hdr_cnt = '0;
            n_length  = '0;
            n_block   = '0;
            n_pay_cnt = '0;
            n_error   = '0;
            n_bcast   = '0;
        end else begin
            unique case (r_kind)
                tftpd_pkg::KIND_NONE: begin
                end
                tftpd_pkg::KIND_RRQ, tftpd_pkg::KIND_WRQ,
                tftpd_pkg::KIND_LOGRQ, tftpd_pkg::KIND_DELRQ: begin
                    res_valid = 1'b1;
                    if (i_byte_value != 8'd0) begin
                        res.payload_valid = 1'b1;
                        res.payload_byte  = i_byte_value;
                    end else begin
                        res.done_res = 1'b1;
                        n_hdr_cnt = '0;
                        n_length  = '0;
                        n_block   = '0;
                        n_pay_cnt = '0;
                        n_error   = '0;
                        n_bcast   = '0;
                    end
                end
                tftpd_pkg::KIND_DATA: begin
                    if (r_hdr_cnt < tftpd_pkg::DATA_HDR_BYTES) begin
                        if (r_hdr_cnt < tftpd_pkg::DATA_LEN_BYTES) begin
                            n_length = len_shift;
                        end else begin
                            n_block = blk_shift;
                        end
                        n_hdr_cnt = hdr_inc;
                        // zero length closes the packet on the last header byte
                        if (hdr_inc == tftpd_pkg::DATA_HDR_BYTES && r_length == 16'd0) begin
                            res_valid          = 1'b1;
                            res.done_res       = 1'b1;
                            res.block_number   = blk_shift;
                            n_hdr_cnt = '0;
                            n_length  = '0;
                            n_block   = '0;
                            n_pay_cnt = '0;
                            n_error   = '0;
                            n_bcast   = '0;
                        end
                    end else begin
                        res_valid          = 1'b1;
                        res.payload_valid  = 1'b1;
                        res.payload_byte   = i_byte_value;
                        res.block_number   = r_block;
                        res.data_size      = r_length;
                        n_pay_cnt          = pay_inc;
                        if (pay_inc == r_length) begin
                            res.done_res = 1'b1;
                            n_hdr_cnt = '0;
                            n_length  = '0;
                            n_block   = '0;
                            n_pay_cnt = '0;
                            n_error   = '0;
                            n_bcast   = '0;
                        end
                    end
                end
                tftpd_pkg::KIND_ACK: begin
                    if (r_hdr_cnt == 3'd0) begin
                        n_block   = blk_shift;
                        n_hdr_cnt = 3'd1;
                    end else begin
                        res_valid        = 1'b1;
                        res.done_res     = 1'b1;
                        res.block_number = blk_shift;
                        n_hdr_cnt = '0;
                        n_length  = '0;
                        n_block   = '0;
                        n_pay_cnt = '0;
                        n_error   = '0;
                        n_bcast   = '0;
                    end
                end
                tftpd_pkg::KIND_ERROR: begin
                    if (r_hdr_cnt < tftpd_pkg::ERR_HDR_BYTES) begin
                        n_error   = err_shift;
                        n_hdr_cnt = hdr_inc;
                    end else if (i_byte_value == 8'd0) begin
                        // drop message bytes, close on the terminator
                        res_valid      = 1'b1;
                        res.done_res   = 1'b1;
                        res.error_code = r_error;
                        n_hdr_cnt = '0;
                        n_length  = '0;
                        n_block   = '0;
                        n_pay_cnt = '0;
                        n_error   = '0;
                        n_bcast   = '0;
                    end
                end
                tftpd_pkg::KIND_DIRQ, tftpd_pkg::KIND_DISC: begin
                    res_valid    = 1'b1;
                    res.done_res = 1'b1;
                    n_hdr_cnt = '0;
                    n_length  = '0;
                    n_block   = '0;
                    n_pay_cnt = '0;
                    n_error   = '0;
                    n_bcast   = '0;
                end
                tftpd_pkg::KIND_BCAST: begin
                    if (r_hdr_cnt == 3'd0) begin
                        n_bcast   = i_byte_value;
                        n_hdr_cnt = 3'd1;
                    end else begin
                        res_valid          = 1'b1;
                        res.broadcast_flag = r_bcast;
                        if (i_byte_value != 8'd0) begin
                            res.payload_valid = 1'b1;
                            res.payload_byte  = i_byte_value;
                        end else begin
                            res.done_res = 1'b1;
                            n_hdr_cnt = '0;
                            n_length  = '0;
                            n_block   = '0;
                            n_pay_cnt = '0;
                            n_error   = '0;
                            n_bcast   = '0;
                        end
                    end
                end
                default: begin
                    res_valid        = 1'b1;
                    res.packet_type  = tftpd_pkg::TYPE_UNKNOWN;
                    res.done_res     = 1'b1;
                    res.error_code   = tftpd_pkg::CODE_UNKNOWN;
                    n_hdr_cnt = '0;
                    n_length  = '0;
                    n_block   = '0;
                    n_pay_cnt = '0;
                    n_error   = '0;
                    n_bcast   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= tftpd_pkg::KIND_NONE;
            r_hdr_cnt <= '0;
            r_length  <= '0;
            r_block   <= '0;
            r_pay_cnt <= '0;
            r_error   <= '0;
            r_bcast   <= '0;
        end else if (acc) begin
            r_kind    <= n_kind;
            r_hdr_cnt <= n_hdr_cnt;
            r_length  <= n_length;
            r_block   <= n_block;
            r_pay_cnt <= n_pay_cnt;
            r_error   <= n_error;
            r_bcast   <= n_bcast;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= acc && res_valid;
            end
        end else if (acc && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (acc && res_valid) begin
                r_out <= res;
            end
        end else if (acc && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_stall          = r_skid_valid;
    assign o_valid          = r_out_valid;
    assign o_packet_type    = r_out.packet_type;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_done_res       = r_out.done_res;
    assign o_block_number   = r_out.block_number;
    assign o_data_size      = r_out.data_size;
    assign o_error_code     = r_out.error_code;
    assign o_broadcast_flag = r_out.broadcast_flag;

endmodule

// ----- tb/tb_tftp_style_packet_deframer_core.sv -----
module tb_tftp_style_packet_deframer_core;
    import tftpd_pkg::*;

    localparam int unsigned RANDOM_BEATS = 1050;
    localparam int unsigned SQUEEZE_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 10;

    class packet_result_board;
        t_kind       kind;
        logic [2:0]  hdr_cnt;
        logic [15:0] data_len;
        logic [15:0] blk_num;
        logic [15:0] pay_cnt;
        logic [15:0] err_code;
        logic [7:0]  bcast_flag;
        t_result     expected_results[$];
        int unsigned mismatches;

        function new();
            kind = KIND_NONE;
            mismatches = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            hdr_cnt = '0;
            data_len = '0;
            blk_num = '0;
            pay_cnt = '0;
            err_code = '0;
            bcast_flag = '0;
        endfunction

        function void post(logic [3:0] ptype, logic pv, logic [7:0] pb, logic done,
                           logic [15:0] blk, logic [15:0] size, logic [15:0] err,
                           logic [7:0] bflag);
            t_result r;
            r.packet_type = ptype;
            r.payload_valid = pv;
            r.payload_byte = pv ? pb : 8'd0;
            r.done_res = done;
            r.block_number = blk;
            r.data_size = size;
            r.error_code = err;
            r.broadcast_flag = bflag;
            expected_results = {expected_results, r};
        endfunction

        // Advance the header state by one accepted beat and queue what it yields.
        function void note_beat(logic cmd, logic [15:0] op, logic [7:0] b);
            logic [3:0] ptype;
            if (cmd == CMD_BEGIN) begin
                if (op == 16'd0) begin
                    kind = KIND_NONE;
                end else if (op <= OPCODE_MAX) begin
                    kind = t_kind'(op[3:0]);
                end else begin
                    kind = KIND_UNKNOWN;
                end
                clear_packet();
                return;
            end
            ptype = 4'(kind) - 4'd1;
            case (kind)
                KIND_NONE: begin
                end
                KIND_RRQ, KIND_WRQ, KIND_LOGRQ, KIND_DELRQ: begin
                    if (b != 8'd0) begin
                        post(ptype, 1'b1, b, 1'b0, '0, '0, '0, '0);
                    end else begin
                        post(ptype, 1'b0, '0, 1'b1, '0, '0, '0, '0);
                        clear_packet();
                    end
                end
                KIND_DATA: begin
                    if (hdr_cnt < DATA_HDR_BYTES) begin
                        if (hdr_cnt < DATA_LEN_BYTES) begin
                            data_len = {data_len[7:0], b};
                        end else begin
                            blk_num = {blk_num[7:0], b};
                        end
                        hdr_cnt = hdr_cnt + 3'd1;
                        if (hdr_cnt == DATA_HDR_BYTES && data_len == 16'd0) begin
                            post(ptype, 1'b0, '0, 1'b1, blk_num, '0, '0, '0);
                            clear_packet();
                        end
                    end else begin
                        pay_cnt = pay_cnt + 16'd1;
                        post(ptype, 1'b1, b, pay_cnt == data_len, blk_num, data_len, '0, '0);
                        if (pay_cnt == data_len) begin
                            clear_packet();
                        end
                    end
                end
                KIND_ACK: begin
                    blk_num = {blk_num[7:0], b};
                    if (hdr_cnt == 3'd0) begin
                        hdr_cnt = 3'd1;
                    end else begin
                        post(ptype, 1'b0, '0, 1'b1, blk_num, '0, '0, '0);
                        clear_packet();
                    end
                end
                KIND_ERROR: begin
                    if (hdr_cnt < ERR_HDR_BYTES) begin
                        err_code = {err_code[7:0], b};
                        hdr_cnt = hdr_cnt + 3'd1;
                    end else if (b == 8'd0) begin
                        post(ptype, 1'b0, '0, 1'b1, '0, '0, err_code, '0);
                        clear_packet();
                    end
                end
                KIND_DIRQ, KIND_DISC: begin
                    post(ptype, 1'b0, '0, 1'b1, '0, '0, '0, '0);
                    clear_packet();
                end
                KIND_BCAST: begin
                    if (hdr_cnt == 3'd0) begin
                        bcast_flag = b;
                        hdr_cnt = 3'd1;
                    end else if (b != 8'd0) begin
                        post(ptype, 1'b1, b, 1'b0, '0, '0, '0, bcast_flag);
                    end else begin
                        post(ptype, 1'b0, '0, 1'b1, '0, '0, '0, bcast_flag);
                        clear_packet();
                    end
                end
                default: begin
                    post(TYPE_UNKNOWN, 1'b0, '0, 1'b1, '0, '0, CODE_UNKNOWN, '0);
                    clear_packet();
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none, actual type %0d byte %0h done %0b",
                         $time, got.packet_type, got.payload_byte, got.done_res);
                return;
            end
            want = expected_results.pop_front();
            compare_field("packet_type", 16'(want.packet_type), 16'(got.packet_type));
            compare_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
            compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
            compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
            compare_field("block_number", want.block_number, got.block_number);
            compare_field("data_size", want.data_size, got.data_size);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("broadcast_flag", 16'(want.broadcast_flag),
                          16'(got.broadcast_flag));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_command;
    logic [15:0] i_opcode_value;
    logic [7:0]  i_byte_value;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_packet_type;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic        o_done_res;
    logic [15:0] o_block_number;
    logic [15:0] o_data_size;
    logic [15:0] o_error_code;
    logic [7:0]  o_broadcast_flag;

    packet_result_board board;
    logic [15:0]        cur_op = 16'd0;
    int unsigned        beats_counted = 0;
    bit                 burst = 1'b0;
    bit                 clean = 1'b0;
    bit                 squeeze_req = 1'b0;

    tftp_style_packet_deframer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_opcode_value   (i_opcode_value),
        .i_byte_value     (i_byte_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_packet_type    (o_packet_type),
        .o_payload_valid  (o_payload_valid),
        .o_payload_byte   (o_payload_byte),
        .o_done_res       (o_done_res),
        .o_block_number   (o_block_number),
        .o_data_size      (o_data_size),
        .o_error_code     (o_error_code),
        .o_broadcast_flag (o_broadcast_flag)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned pick_gap(bit no_idle);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one beat and hold it until accepted.
    task automatic send_beat(logic cmd, logic [15:0] op, logic [7:0] b);
        int unsigned gap;
        i_valid <= 1'b1;
        i_command <= cmd;
        i_opcode_value <= op;
        i_byte_value <= b;
        do @(posedge i_clk); while (o_stall);
        board.note_beat(cmd, op, b);
        if (cmd == CMD_BEGIN) begin
            cur_op = op;
        end
        if (cmd == CMD_BEGIN || cur_op != 16'd0) begin
            beats_counted++;
        end
        gap = pick_gap(burst);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic open_packet(logic [15:0] op);
        send_beat(CMD_BEGIN, op, 8'($urandom));
    endtask

    task automatic push_byte(logic [7:0] b);
        send_beat(CMD_BODY, 16'($urandom), b);
    endtask

    task automatic push_name(int unsigned max_len);
        repeat ($urandom_range(0, max_len)) push_byte(8'($urandom_range(1, 255)));
        push_byte(8'd0);
    endtask

    task automatic send_packet();
        int unsigned r;
        int unsigned sel;
        logic [15:0] op;
        logic [15:0] dlen;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0) begin
            burst = !burst;
        end
        if (r < 85) begin
            op = 16'($urandom_range(1, 10));
            // Reuse the opcode in force: a finished packet leaves it set.
            if (clean && cur_op >= 16'd1 && cur_op <= OPCODE_MAX && $urandom_range(0, 3) == 0) begin
                op = cur_op;
            end else begin
                open_packet(op);
            end
            case (t_kind'(op[3:0]))
                KIND_DATA: begin
                    dlen = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(100, 400))
                                                        : 16'($urandom_range(0, 8));
                    push_byte(dlen[15:8]);
                    push_byte(dlen[7:0]);
                    push_byte(8'($urandom));
                    push_byte(8'($urandom));
                    repeat (dlen) push_byte(8'($urandom));
                end
                KIND_ACK: begin
                    push_byte(8'($urandom));
                    push_byte(8'($urandom));
                end
                KIND_ERROR: begin
                    push_byte(8'($urandom));
                    push_byte(8'($urandom));
                    push_name(8);
                end
                KIND_DIRQ, KIND_DISC: begin
                    push_byte(8'($urandom));
                end
                KIND_BCAST: begin
                    push_byte(8'($urandom));
                    push_name(10);
                end
                default: begin
                    push_name(12);
                end
            endcase
            clean = 1'b1;
        end else if (r < 95) begin
            // Broken packet: random opcode and raw bytes, cut off by the next begin.
            sel = $urandom_range(0, 3);
            case (sel)
                0: op = 16'($urandom_range(1, 10));
                1: op = 16'($urandom_range(11, 65535));
                2: op = 16'd0;
                default: op = 16'($urandom);
            endcase
            open_packet(op);
            repeat ($urandom_range(0, 12)) push_byte(8'($urandom));
            clean = 1'b0;
        end else begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
            clean = 1'b0;
        end
    endtask

    initial begin
        int unsigned target;
        board = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= CMD_BODY;
        i_opcode_value <= 16'd0;
        i_byte_value <= 8'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Body byte before any opcode: dropped.
        push_byte(8'hff);
        open_packet(16'd1);
        push_byte(8'h41);
        push_byte(8'h00);
        // DATA with length 1 and block 0xffff.
        open_packet(16'd3);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'hff);
        push_byte(8'hff);
        push_byte(8'hff);
        // ACK restarted in mid-packet.
        open_packet(16'd4);
        push_byte(8'hff);
        open_packet(16'd4);
        push_byte(8'hff);
        push_byte(8'hff);
        open_packet(16'd5);
        push_byte(8'hff);
        push_byte(8'hff);
        push_byte(8'h00);
        open_packet(16'd6);
        push_byte(8'h00);
        open_packet(16'd9);
        push_byte(8'hff);
        push_byte(8'h6e);
        push_byte(8'h00);
        open_packet(16'hffff);
        push_byte(8'h00);
        // Opcode zero: bytes ignored again.
        open_packet(16'd0);
        push_byte(8'h55);

        squeeze_req = 1'b1;
        target = beats_counted + RANDOM_BEATS;
        while (beats_counted < target) begin
            send_packet();
        end
        i_valid <= 1'b0;

        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off so the input backs up.
    initial begin
        int unsigned n;
        i_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                i_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            repeat (n) @(posedge i_clk);
            n = pick_gap(1'b0);
            if (n != 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.packet_type = o_packet_type;
            got.payload_valid = o_payload_valid;
            got.payload_byte = o_payload_byte;
            got.done_res = o_done_res;
            got.block_number = o_block_number;
            got.data_size = o_data_size;
            got.error_code = o_error_code;
            got.broadcast_flag = o_broadcast_flag;
            board.check_result(got);
        end
    end

    initial begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

endmodule
